### rtl/gbf_pkg.sv
// ----------------------------------------------------------------------------
// gbf_pkg
// Shared types, operation codes and defaults for the graph bridge finder.
// ----------------------------------------------------------------------------
package gbf_pkg;

  localparam int unsigned MaxNodesDef     = 1024;
  localparam int unsigned MaxEdgeSlotsDef = 4096;
  localparam int unsigned CfgW            = 11;

  // operation codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [9:0] node_a;
    logic [9:0] node_b;
    logic [9:0] bridge_index;
  } gbf_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] bridge_count;
    logic [9:0] end_parent;
    logic [9:0] end_child;
  } gbf_out_t;

endpackage

### rtl/graph_bridge_finder.sv
// ----------------------------------------------------------------------------
// graph_bridge_finder
// Bridge finder for an undirected graph: low-link DFS on an explicit stack.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                       | transfer when
//  --------+-----------+-------------------------------+-------------------------
//  in      | input     | gbf_in_t (func, nodes, index) | in_valid_i & in_ready_o
//  out     | output    | gbf_out_t (status, count,...) | out_valid_o & out_ready_i
//  cfg     | input     | node_count, 11 bits           | cfg_valid_i & cfg_ready_o
//
//  Clear sweeps the head table; out-of-range adds and reads answer with no table access.
//  Run sweeps the node table, probes each root, scans the edge slots of a node in two
//  scans (descend, then fold in child low links), pushes each root and each child,
//  finishes, pops and resumes, then collects the bridges node by node.
//  After reset the head table is swept with no item taken.
//  The result register lets the next item in while a result waits.
//
module graph_bridge_finder
  import gbf_pkg::*;
#(
  parameter int unsigned MAX_NODES      = MaxNodesDef,
  parameter int unsigned MAX_EDGE_SLOTS = MaxEdgeSlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gbf_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gbf_out_t        out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned NW  = $clog2(MAX_NODES);        // node index
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);    // node count / time
  localparam int unsigned SW  = $clog2(MAX_EDGE_SLOTS);   // slot index
  localparam int unsigned PW  = $clog2(MAX_EDGE_SLOTS + 1); // slot or null
  localparam int unsigned NRW = 1 + 2 * NCW + PW;         // node record
  localparam int unsigned ERW = NW + PW;                  // edge record
  localparam int unsigned SRW = NW + PW;                  // stack record
  localparam logic [PW-1:0] NIL = PW'(MAX_EDGE_SLOTS);

  typedef enum logic [5:0] {
    S_HCLR, S_IDLE, S_ADD_A, S_ADD_A2, S_ADD_B, S_ADD_B2,
    S_RD_L, S_RD_P, S_RD_C, S_RD_X,
    S_NCLR, S_ROOT, S_ROOT_W, S_TOP, S_TOP_W, S_TOP_N,
    S_SCAN, S_SCAN_E, S_SCAN_N, S_DESC, S_HEAD, S_PUSH,
    S_FIN, S_FIN_H, S_FIN_L, S_FIN_E, S_FIN_N, S_POP,
    S_COL, S_COL_N, S_COL_E, S_COL_U, S_DONE
  } state_e;

  state_e          state_q;
  logic [CfgW-1:0] nc_q;
  logic [PW-1:0]   fill_q;
  logic [NCW-1:0]  bf_q;
  logic [NCW-1:0]  vc_q;
  logic [NCW-1:0]  sd_q;
  logic [NCW-1:0]  i_q;
  logic            clr_item_q;
  gbf_in_t         item_q;
  logic [1:0]      status_q;
  logic [NW-1:0]   par_q;
  logic [NW-1:0]   chi_q;
  logic [NW-1:0]   u_q;
  logic [NW-1:0]   v_q;
  logic [PW-1:0]   e_q;
  logic [PW-1:0]   link_q;
  logic [NCW-1:0]  disc_u_q;
  logic [NCW-1:0]  low_u_q;
  logic [PW-1:0]   tpe_u_q;
  logic [PW-1:0]   tpe_v_q;
  logic            out_valid_q;
  gbf_out_t        out_q;

  // memory ports
  logic           h_we, e_we, n_we, s_we, l_we;
  logic [NW-1:0]  h_wa, h_ra, n_wa, n_ra, s_wa, s_ra, l_wa, l_ra;
  logic [SW-1:0]  e_wa, e_ra;
  logic [PW-1:0]  h_wd, h_rd;
  logic [ERW-1:0] e_wd, e_rd;
  logic [NRW-1:0] n_wd, n_rd;
  logic [SRW-1:0] s_wd, s_rd;
  logic [SW-1:0]  l_wd, l_rd;

  logic           n_rd_seen;
  logic [NCW-1:0] n_rd_disc, n_rd_low;
  logic [PW-1:0]  n_rd_tpe;
  logic [NW-1:0]  e_rd_tgt, s_rd_node;
  logic [PW-1:0]  e_rd_link, s_rd_cur;
  logic [PW-1:0]  fill_p1;
  logic [NW-1:0]  top_idx;
  logic [PW-1:0]  e_pair;

  assign n_rd_seen = n_rd[NRW-1];
  assign n_rd_disc = n_rd[PW+2*NCW-1 -: NCW];
  assign n_rd_low  = n_rd[PW+NCW-1 -: NCW];
  assign n_rd_tpe  = n_rd[PW-1:0];
  assign e_rd_tgt  = e_rd[ERW-1 -: NW];
  assign e_rd_link = e_rd[PW-1:0];
  assign s_rd_node = s_rd[SRW-1 -: NW];
  assign s_rd_cur  = s_rd[PW-1:0];
  assign fill_p1   = fill_q + PW'(1);
  assign top_idx   = NW'(sd_q - NCW'(1));
  assign e_pair    = e_q ^ PW'(1);

  // Steer the memory ports from the sequencer state.
  always_comb begin
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = e_q[SW-1:0];
    n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = top_idx;
    l_we = 1'b0; l_wa = bf_q[NW-1:0]; l_wd = e_q[SW-1:0];
    l_ra = NW'(item_q.bridge_index);
    case (state_q)
      S_HCLR: begin
        h_we = 1'b1; h_wa = i_q[NW-1:0]; h_wd = NIL;
      end
      S_ADD_A:  h_ra = NW'(item_q.node_a);
      S_ADD_A2: begin
        h_we = 1'b1; h_wa = NW'(item_q.node_a); h_wd = fill_q;
        e_we = 1'b1; e_wa = fill_q[SW-1:0]; e_wd = {NW'(item_q.node_b), h_rd};
      end
      S_ADD_B:  h_ra = NW'(item_q.node_b);
      S_ADD_B2: begin
        h_we = 1'b1; h_wa = NW'(item_q.node_b); h_wd = fill_p1;
        e_we = 1'b1; e_wa = fill_p1[SW-1:0]; e_wd = {NW'(item_q.node_a), h_rd};
      end
      S_RD_P: e_ra = l_rd;
      S_RD_C: e_ra = e_pair[SW-1:0];
      S_NCLR: begin
        n_we = 1'b1; n_wa = i_q[NW-1:0]; n_wd = {1'b0, NCW'(0), NCW'(0), NIL};
      end
      S_ROOT:   n_ra = i_q[NW-1:0];
      S_TOP_W:  n_ra = s_rd_node;
      S_SCAN_E: n_ra = e_rd_tgt;
      S_DESC: begin
        n_we = 1'b1; n_wa = u_q; n_wd = {1'b1, disc_u_q, low_u_q, tpe_u_q};
        s_we = 1'b1; s_wa = top_idx; s_wd = {u_q, link_q};
      end
      S_HEAD: h_ra = v_q;
      S_PUSH: begin
        n_we = 1'b1; n_wa = v_q; n_wd = {1'b1, vc_q, vc_q, tpe_v_q};
        s_we = 1'b1; s_wa = sd_q[NW-1:0]; s_wd = {v_q, h_rd};
      end
      S_FIN:    h_ra = u_q;
      S_FIN_E:  n_ra = e_rd_tgt;
      S_POP: begin
        n_we = 1'b1; n_wa = u_q; n_wd = {1'b1, disc_u_q, low_u_q, tpe_u_q};
      end
      S_COL:    n_ra = i_q[NW-1:0];
      S_COL_N:  e_ra = n_rd_tpe[SW-1:0];
      S_COL_E:  n_ra = e_rd_tgt;
      S_COL_U:  l_we = (n_rd_disc < low_u_q) && (32'(bf_q) < MAX_NODES);
      default: ;
    endcase
  end

  // Sequencer: state, walk registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HCLR;
      nc_q        <= CfgW'(1);
      fill_q      <= '0;
      bf_q        <= '0;
      vc_q        <= '0;
      sd_q        <= '0;
      i_q         <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        // saturate the node count at the table size
        nc_q <= (32'(cfg_data_i) > MAX_NODES) ? CfgW'(MAX_NODES) : cfg_data_i;
      end
      // drop the result once taken, unless a new one is loaded this cycle
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_HCLR: begin
          i_q <= i_q + NCW'(1);
          if (32'(i_q) == MAX_NODES - 1) begin
            state_q <= clr_item_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            item_q     <= in_data_i;
            par_q      <= '0;
            chi_q      <= '0;
            clr_item_q <= (in_data_i.func == FUNC_CLEAR);
            case (in_data_i.func)
              FUNC_CLEAR: begin
                status_q   <= STAT_OK;
                fill_q     <= '0;
                bf_q       <= '0;
                i_q        <= '0;
                state_q    <= S_HCLR;
              end
              FUNC_ADD: begin
                if ({1'b0, in_data_i.node_a} >= nc_q ||
                    {1'b0, in_data_i.node_b} >= nc_q) begin
                  status_q <= STAT_RANGE;
                  state_q  <= S_DONE;
                end else if (32'(fill_q) + 32'd2 > MAX_EDGE_SLOTS) begin
                  status_q <= STAT_FULL;
                  state_q  <= S_DONE;
                end else begin
                  status_q <= STAT_OK;
                  state_q  <= S_ADD_A;
                end
              end
              FUNC_RUN: begin
                status_q <= STAT_OK;
                vc_q     <= '0;
                sd_q     <= '0;
                bf_q     <= '0;
                i_q      <= '0;
                state_q  <= S_NCLR;
              end
              default: begin
                if (32'(in_data_i.bridge_index) >= 32'(bf_q) ||
                    32'(in_data_i.bridge_index) >= MAX_NODES) begin
                  status_q <= STAT_RANGE;
                  state_q  <= S_DONE;
                end else begin
                  status_q <= STAT_OK;
                  state_q  <= S_RD_L;
                end
              end
            endcase
          end
        end
        S_ADD_A:  state_q <= S_ADD_A2;
        S_ADD_A2: state_q <= S_ADD_B;
        S_ADD_B:  state_q <= S_ADD_B2;
        S_ADD_B2: begin
          fill_q  <= fill_q + PW'(2);
          state_q <= S_DONE;
        end
        S_RD_L: state_q <= S_RD_P;
        S_RD_P: begin
          e_q     <= PW'(l_rd);
          state_q <= S_RD_C;
        end
        S_RD_C: begin
          par_q   <= e_rd_tgt;
          state_q <= S_RD_X;
        end
        S_RD_X: begin
          chi_q   <= e_rd_tgt;
          state_q <= S_DONE;
        end
        S_NCLR: begin
          if (32'(i_q) == MAX_NODES - 1) begin
            i_q     <= '0;
            state_q <= S_ROOT;
          end else begin
            i_q <= i_q + NCW'(1);
          end
        end
        // next unvisited root in ascending order
        S_ROOT: begin
          if (32'(i_q) >= 32'(nc_q)) begin
            i_q     <= '0;
            state_q <= S_COL;
          end else begin
            state_q <= S_ROOT_W;
          end
        end
        S_ROOT_W: begin
          if (n_rd_seen) begin
            i_q     <= i_q + NCW'(1);
            state_q <= S_ROOT;
          end else begin
            v_q     <= i_q[NW-1:0];
            tpe_v_q <= NIL;
            state_q <= S_HEAD;
          end
        end
        S_TOP: begin
          if (sd_q == '0) begin
            i_q     <= i_q + NCW'(1);
            state_q <= S_ROOT;
          end else begin
            state_q <= S_TOP_W;
          end
        end
        S_TOP_W: begin
          u_q     <= s_rd_node;
          e_q     <= s_rd_cur;
          state_q <= S_TOP_N;
        end
        S_TOP_N: begin
          disc_u_q <= n_rd_disc;
          low_u_q  <= n_rd_low;
          tpe_u_q  <= n_rd_tpe;
          state_q  <= S_SCAN;
        end
        // resume the edge scan of the node on top of the stack
        S_SCAN: state_q <= (e_q < fill_q) ? S_SCAN_E : S_FIN;
        S_SCAN_E: begin
          link_q <= e_rd_link;
          if (e_q != tpe_u_q) begin
            state_q <= S_SCAN_N;
          end else begin
            e_q     <= e_rd_link;
            state_q <= S_SCAN;
          end
        end
        S_SCAN_N: begin
          if (!n_rd_seen) begin
            v_q     <= e_rd_tgt;
            tpe_v_q <= e_pair;
            state_q <= S_DESC;
          end else begin
            if (n_rd_disc < low_u_q) begin
              low_u_q <= n_rd_disc;
            end
            e_q     <= link_q;
            state_q <= S_SCAN;
          end
        end
        S_DESC: state_q <= S_HEAD;
        S_HEAD: state_q <= S_PUSH;
        S_PUSH: begin
          vc_q    <= vc_q + NCW'(1);
          sd_q    <= sd_q + NCW'(1);
          state_q <= S_TOP;
        end
        // all edges seen: fold in the low links of tree children
        S_FIN:   state_q <= S_FIN_H;
        S_FIN_H: begin
          e_q     <= h_rd;
          state_q <= S_FIN_L;
        end
        S_FIN_L: state_q <= (e_q < fill_q) ? S_FIN_E : S_POP;
        S_FIN_E: begin
          link_q  <= e_rd_link;
          state_q <= S_FIN_N;
        end
        S_FIN_N: begin
          if (n_rd_tpe == e_pair && n_rd_low < low_u_q) begin
            low_u_q <= n_rd_low;
          end
          e_q     <= link_q;
          state_q <= S_FIN_L;
        end
        S_POP: begin
          sd_q    <= sd_q - NCW'(1);
          state_q <= S_TOP;
        end
        // collect bridges in ascending child order
        S_COL: state_q <= (32'(i_q) >= 32'(nc_q)) ? S_DONE : S_COL_N;
        S_COL_N: begin
          if (n_rd_tpe < fill_q) begin
            e_q     <= n_rd_tpe;
            low_u_q <= n_rd_low;
            state_q <= S_COL_E;
          end else begin
            i_q     <= i_q + NCW'(1);
            state_q <= S_COL;
          end
        end
        S_COL_E: state_q <= S_COL_U;
        S_COL_U: begin
          if (l_we) begin
            bf_q <= bf_q + NCW'(1);
          end
          i_q     <= i_q + NCW'(1);
          state_q <= S_COL;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q        <= 1'b1;
            out_q.status       <= status_q;
            out_q.bridge_count <= 10'(bf_q);
            out_q.end_parent   <= 10'(par_q);
            out_q.end_child    <= 10'(chi_q);
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  gbf_ram #(.Width(PW), .Depth(MAX_NODES)) u_head (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd)
  );

  gbf_ram #(.Width(ERW), .Depth(MAX_EDGE_SLOTS)) u_edge (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rd)
  );

  gbf_ram #(.Width(NRW), .Depth(MAX_NODES)) u_node (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd), .raddr_i(n_ra), .rdata_o(n_rd)
  );

  gbf_ram #(.Width(SRW), .Depth(MAX_NODES)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd)
  );

  gbf_ram #(.Width(SW), .Depth(MAX_NODES)) u_list (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/gbf_ram.sv
// ----------------------------------------------------------------------------
// gbf_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### dv/gbf_checker.sv
// ----------------------------------------------------------------------------
// gbf_checker
// Watches the item, result and register channels of the bridge finder, keeps
// its own copy of the graph, predicts each answer and compares it as a whole
// with the results that come out of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gbf_checker
  import gbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  gbf_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  gbf_out_t    out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [10:0] cfg_data_i,
  output int          fail_count_o,
  output int          answers_pending_o
);

  localparam int NODES = 1024;
  localparam int SLOTS = 4096;
  localparam int NIL   = SLOTS;

  int unsigned head[NODES];
  int unsigned tgt[SLOTS];
  int unsigned nxt[SLOTS];
  int unsigned fill;
  int unsigned disc[NODES];
  int unsigned low[NODES];
  int unsigned par_edge[NODES];
  bit          seen[NODES];
  int unsigned stk_node[NODES];
  int unsigned stk_cur[NODES];
  int unsigned depth;
  int unsigned clock_n;
  int unsigned bridges[NODES];
  int unsigned n_bridges;
  int unsigned n_nodes;
  gbf_out_t    answers[$];

  assign answers_pending_o = answers.size();

  function automatic bit slot_valid(int unsigned e);
    return e < fill && e < SLOTS;
  endfunction

  function automatic void visit(int unsigned v);
    if (v >= NODES || depth >= NODES) return;
    stk_node[depth] = v;
    stk_cur[depth]  = head[v];
    seen[v]  = 1'b1;
    disc[v]  = clock_n;
    low[v]   = clock_n;
    clock_n++;
    depth++;
  endfunction

  function automatic void walk_tree(int unsigned root);
    int unsigned top, u, e, v, w;
    bit down;
    visit(root);
    while (depth > 0) begin
      top  = depth - 1;
      u    = stk_node[top];
      e    = stk_cur[top];
      down = 1'b0;
      v    = 0;
      while (slot_valid(e)) begin
        if (e != par_edge[u]) begin
          w = tgt[e];
          if (!seen[w]) begin
            down = 1'b1;
            v = w;
            break;
          end
          if (disc[w] < low[u]) low[u] = disc[w];
        end
        e = nxt[e];
      end
      if (down) begin
        par_edge[v] = e ^ 1;
        stk_cur[top] = nxt[e];
        visit(v);
      end else begin
        // fold child low links back once all neighbors are done
        for (e = head[u]; slot_valid(e); e = nxt[e]) begin
          w = tgt[e];
          if (par_edge[w] == (e ^ 1) && low[w] < low[u]) low[u] = low[w];
        end
        depth--;
      end
    end
  endfunction

  function automatic void find_bridges();
    int unsigned pe;
    clock_n = 0;
    depth = 0;
    n_bridges = 0;
    for (int i = 0; i < NODES; i++) begin
      seen[i] = 1'b0;
      disc[i] = 0;
      low[i] = 0;
      par_edge[i] = NIL;
    end
    for (int unsigned i = 0; i < n_nodes; i++)
      if (!seen[i]) walk_tree(i);
    for (int unsigned i = 0; i < n_nodes; i++) begin
      pe = par_edge[i];
      if (slot_valid(pe) && disc[tgt[pe]] < low[i] && n_bridges < NODES) begin
        bridges[n_bridges] = pe;
        n_bridges++;
      end
    end
  endfunction

  function automatic gbf_out_t answer_item(gbf_in_t it);
    gbf_out_t r;
    int unsigned s;
    r = '0;
    r.status = STAT_OK;
    case (it.func)
      FUNC_CLEAR: begin
        for (int i = 0; i < NODES; i++) head[i] = NIL;
        fill = 0;
        n_bridges = 0;
      end
      FUNC_ADD: begin
        if (it.node_a >= n_nodes || it.node_b >= n_nodes) begin
          r.status = STAT_RANGE;
        end else if (fill + 2 > SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          s = fill;
          tgt[s] = 32'(it.node_b);
          nxt[s] = head[it.node_a];
          head[it.node_a] = s;
          tgt[s+1] = 32'(it.node_a);
          nxt[s+1] = head[it.node_b];
          head[it.node_b] = s + 1;
          fill = s + 2;
        end
      end
      FUNC_RUN: find_bridges();
      default: begin
        if (it.bridge_index >= n_bridges) begin
          r.status = STAT_RANGE;
        end else begin
          r.end_parent = 10'(tgt[bridges[it.bridge_index]]);
          r.end_child  = 10'(tgt[bridges[it.bridge_index] ^ 1]);
        end
      end
    endcase
    r.bridge_count = n_bridges[9:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gbf_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) head[i] = NIL;
      fill = 0;
      n_bridges = 0;
      n_nodes = 1;
      fail_count_o <= 0;
      answers.delete();
    end else begin
      // check the result first: a transfer in this cycle can not answer itself
      if (out_valid_i && out_ready_i) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answers.pop_front();
          if (want !== out_data_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) answers = {answers, answer_item(in_data_i)};
      if (cfg_valid_i && cfg_ready_i)
        n_nodes = 32'(cfg_data_i) > NODES ? NODES : 32'(cfg_data_i);
    end
  end

endmodule

### dv/tb_graph_bridge_finder.sv
// ----------------------------------------------------------------------------
// tb_graph_bridge_finder
// Stimulus and verdict for the bridge finder: register writes between phases,
// a directed graph set, then random graphs built as loaded edge sets followed
// by a search and reads, with random idling on both sides and one long
// receiver hold-off. Checking lives in gbf_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_graph_bridge_finder;
  import gbf_pkg::*;

  localparam int WATCHDOG = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  gbf_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  gbf_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i = '0;
  int          fail_count;
  int          answers_pending;
  bit          calm = 1'b0;      // no idling while set
  bit          hold_off = 1'b0;  // receiver held off while set
  int          quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  graph_bridge_finder dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  gbf_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .answers_pending_o(answers_pending)
  );

  // receiver: stall at random, or hold off entirely during the pressure stretch
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= calm || ($urandom_range(99) >= 36);
  end

  // watchdog: count cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || hold_off)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one item transfer, with a random gap in front of it; valid stays high
  // after the transfer until the next gap or the caller drops it
  task automatic send(logic [1:0] f, int a, int b, int idx);
    gbf_in_t it;
    it.func = f;
    it.node_a = a[9:0];
    it.node_b = b[9:0];
    it.bridge_index = idx[9:0];
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drain all answers, let the block settle, then write the node count
  task automatic set_nodes(int n);
    in_valid_i <= 1'b0;
    while (answers_pending != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n[10:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // random graph of n nodes: a tree, a few cycle-closing and parallel edges,
  // a little noise, then a search and reads across and past the list
  task automatic random_graph(int n, int edges);
    int a, b;
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(9) == 0) begin
        a = $urandom_range(1023);
        b = $urandom_range(1023);
      end else begin
        b = $urandom_range(n - 1);
        a = (b == 0 || $urandom_range(4) == 0) ? $urandom_range(n - 1)
                                               : $urandom_range(b - 1);
      end
      send(FUNC_ADD, a, b, $urandom_range(1023));
    end
    send(FUNC_RUN, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
    for (int i = 0; i < 6; i++)
      send(FUNC_READ, $urandom_range(1023), $urandom_range(1023),
           ($urandom_range(5) == 0) ? $urandom_range(1023) : $urandom_range(n));
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero nodes, out-of-range endpoints, self loop, read past list
    calm = 1'b1;
    set_nodes(0);
    send(FUNC_ADD, 0, 0, 0);
    set_nodes(2047);
    send(FUNC_ADD, 1023, 0, 0);
    send(FUNC_ADD, 1023, 1023, 1023);
    send(FUNC_RUN, 0, 0, 0);
    send(FUNC_CLEAR, 0, 0, 0);
    set_nodes(6);
    send(FUNC_ADD, 0, 1, 0);
    send(FUNC_ADD, 1, 2, 0);
    send(FUNC_ADD, 2, 0, 0);
    send(FUNC_ADD, 2, 3, 0);
    send(FUNC_ADD, 3, 4, 0);
    send(FUNC_ADD, 3, 4, 0);  // doubled edge is no bridge
    send(FUNC_ADD, 4, 5, 0);
    send(FUNC_ADD, 5, 5, 0);  // self loop
    send(FUNC_ADD, 6, 0, 0);  // out of range
    send(FUNC_RUN, 0, 0, 0);
    for (int i = 0; i < 4; i++) send(FUNC_READ, 0, 0, i);
    send(FUNC_READ, 0, 0, 1023);
    set_nodes(4);              // shrink: fewer roots, same stored edges
    send(FUNC_RUN, 0, 0, 0);
    send(FUNC_READ, 0, 0, 0);
    send(FUNC_CLEAR, 0, 0, 0);
    send(FUNC_READ, 0, 0, 0);

    // long chain over the first 301 nodes for a deep stack, then a doubled link
    set_nodes(1024);
    for (int i = 0; i < 300; i++) begin
      if (i == 100) calm = 1'b0;
      send(FUNC_ADD, i, i + 1, 0);
    end
    send(FUNC_ADD, 1, 2, 0);
    send(FUNC_RUN, 0, 0, 0);
    send(FUNC_READ, 0, 0, 0);
    send(FUNC_CLEAR, 0, 0, 0);

    // pressure: hold the receiver off while items keep coming
    set_nodes(12);
    hold_off = 1'b1;
    fork
      random_graph(12, 10);
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    send(FUNC_CLEAR, 0, 0, 0);

    // random phases, mostly small graphs, one long calm stretch
    for (int p = 0; p < 18; p++) begin
      n = (p % 8 == 7) ? 1024 : $urandom_range(2, 24);
      set_nodes(n);
      calm = (p >= 10 && p < 14);
      random_graph(n, $urandom_range(4, 30));
      send(FUNC_CLEAR, 0, 0, 0);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (answers_pending != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && answers_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
